FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond)

`define ASSERT_IMPLY(label, clk, rst_n, pre, post)

`define ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

FILE: sv/msm_pkg.sv
// ----------------------------------------------------------------------------
// Sliding median package
// Field widths, stream packing, controller states and command/status types.
// ----------------------------------------------------------------------------
package msm_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int LEAD_W      = 2;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;
  localparam int TDATA_PAD_W = IN_TDATA_W - SAMPLE_W - LEAD_W;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [LEAD_W-1:0]          lead_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SORT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic insert;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic last_step;
    logic out_busy;
  } dp_sts_t;

endpackage

FILE: sv/multichannel_sliding_median.sv
// ----------------------------------------------------------------------------
// Multichannel sliding median
// Per-lead median over the new sample and the last WINDOW_SPAN samples.
// ----------------------------------------------------------------------------
// channel  | direction | tdata (low bit first)        | tuser
// s_axis   | in        | sample[23:0], lead[25:24]    | clear_history
// m_axis   | out       | median[23:0], lead_out[25:24]| -
//
// Each transaction makes one history memory read per history slot, each
// read fed into the insertion sorter after the new sample.
// Reset clears the per-lead ring pointers and full flags; there is no memory sweep.
// A stalled result holds in the output register while the next transaction
// is accepted and sorted; its result then holds in the sorter, with the
// controller waiting and the input stalled, until that register is free to take it.
module multichannel_sliding_median #(
  parameter int WINDOW_SPAN = 6,
  parameter int LEADS       = 3
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // sample[23:0], lead[25:24], zero pad
  input  logic [msm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // clear_history[0]
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // median[23:0], lead_out[25:24], zero pad
  output logic [msm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import msm_pkg::*;

  `include "assert_macros.svh"

  dp_cmd_t cmd;
  dp_sts_t sts;
  sample_t median;
  lead_t   lead_out;

  msm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  msm_datapath #(
    .WINDOW_SPAN (WINDOW_SPAN),
    .LEADS       (LEADS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .sample_i    (s_axis_tdata[SAMPLE_W-1:0]),
    .lead_i      (s_axis_tdata[SAMPLE_W+LEAD_W-1:SAMPLE_W]),
    .clear_i     (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .median_o    (median),
    .lead_o      (lead_out)
  );

  assign m_axis_tdata = {{TDATA_PAD_W{1'b0}}, lead_out, median};

  `ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `ASSERT_IMPLY(a_emit_into_free, clk_i, rst_ni, cmd.emit, !(m_axis_tvalid && !m_axis_tready))
  `ASSERT_IMPLY(a_valid_from_emit, clk_i, rst_ni, $rose(m_axis_tvalid), $past(cmd.emit))
  `ASSERT_ALWAYS(a_cmd_exclusive, clk_i, rst_ni, !(cmd.load && cmd.insert))

endmodule

FILE: sv/msm_ctrl.sv
// ----------------------------------------------------------------------------
// Sliding median controller
// Sequences accept, window sort and result hand-off for one transaction.
// ----------------------------------------------------------------------------
module msm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  msm_pkg::dp_sts_t sts_i,
  output msm_pkg::dp_cmd_t cmd_o
);
  import msm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SORT;
        end
      end
      ST_SORT: begin
        if (sts_i.last_step) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!sts_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SORT: begin
        cmd_o.insert = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.emit = !sts_i.out_busy;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

FILE: sv/msm_datapath.sv
// ----------------------------------------------------------------------------
// Sliding median datapath
// Per-lead history memory, insertion sorter and registered result stage.
// ----------------------------------------------------------------------------
module msm_datapath #(
  parameter int WINDOW_SPAN = 6,
  parameter int LEADS       = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  msm_pkg::dp_cmd_t cmd_i,
  output msm_pkg::dp_sts_t sts_o,
  input  msm_pkg::sample_t sample_i,
  input  msm_pkg::lead_t   lead_i,
  input  logic             clear_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output msm_pkg::sample_t median_o,
  output msm_pkg::lead_t   lead_o
);
  import msm_pkg::*;

  localparam int NLEADS = (LEADS < (1 << LEAD_W)) ? LEADS : (1 << LEAD_W);
  localparam int LIDX_W = (NLEADS > 1) ? $clog2(NLEADS) : 1;
  localparam int SLOT_W = $clog2(WINDOW_SPAN);
  localparam int ADDR_W = LIDX_W + SLOT_W;
  localparam int STEP_W = $clog2(WINDOW_SPAN + 1);
  localparam int MID    = WINDOW_SPAN / 2;
  localparam int NPTR   = 1 << LIDX_W;

  localparam logic [LEAD_W:0]   LEAD_LIM  = (LEAD_W + 1)'(NLEADS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(WINDOW_SPAN);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_SPAN - 1);

  sample_t                  sample_q;
  lead_t                    lead_q;
  logic                     lead_ok_q;
  logic [STEP_W-1:0]        step_q;
  sample_t                  sort_q [0:WINDOW_SPAN];
  sample_t                  sort_d [0:WINDOW_SPAN];
  logic [WINDOW_SPAN:0]     sort_vld_q;
  logic [WINDOW_SPAN:0]     gt;
  sample_t                  rd_data_q;
  logic                     rd_vld_q;
  logic [SLOT_W-1:0]        wptr_q [0:NPTR-1];
  logic [NPTR-1:0]          full_q;
  sample_t                  mem [0:(1 << ADDR_W)-1];
  logic                     out_valid_q;
  sample_t                  median_q;
  lead_t                    lead_out_q;

  logic [LIDX_W-1:0]        lidx;
  logic [SLOT_W-1:0]        rd_slot;
  logic                     last_step;
  logic                     rd_en;
  logic                     commit;
  sample_t                  key;

  assign lidx      = lead_q[LIDX_W-1:0];
  assign rd_slot   = step_q[SLOT_W-1:0];
  assign last_step = (step_q == LAST_STEP);
  assign rd_en     = cmd_i.insert && !last_step;
  assign commit    = cmd_i.insert && last_step && lead_ok_q;

  assign key = (step_q == '0) ? sample_q : (rd_vld_q ? rd_data_q : '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= sample_i;
      lead_q   <= lead_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_ok_q  <= 1'b0;
      step_q     <= '0;
      sort_vld_q <= '0;
    end else if (cmd_i.load) begin
      lead_ok_q  <= ({1'b0, lead_i} < LEAD_LIM);
      step_q     <= '0;
      sort_vld_q <= '0;
    end else if (cmd_i.insert) begin
      sort_vld_q <= {sort_vld_q[WINDOW_SPAN-1:0], 1'b1};
      if (!last_step) begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  // per-lead ring pointers; a slot below the pointer or in a full ring holds data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NPTR; i++) begin
        wptr_q[i] <= '0;
      end
      full_q <= '0;
    end else if (cmd_i.load && clear_i) begin
      for (int i = 0; i < NPTR; i++) begin
        wptr_q[i] <= '0;
      end
      full_q <= '0;
    end else if (commit) begin
      if (wptr_q[lidx] == LAST_SLOT) begin
        wptr_q[lidx] <= '0;
        full_q[lidx] <= 1'b1;
      end else begin
        wptr_q[lidx] <= wptr_q[lidx] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      mem[{lidx, wptr_q[lidx]}] <= sample_q;
    end
    if (rd_en) begin
      rd_data_q <= mem[{lidx, rd_slot}];
      rd_vld_q  <= lead_ok_q && (full_q[lidx] || (rd_slot < wptr_q[lidx]));
    end
  end

  // insert key into ascending list, empty places count as above everything
  always_comb begin
    for (int p = 0; p <= WINDOW_SPAN; p++) begin
      gt[p] = !sort_vld_q[p] || (sort_q[p] > key);
    end
    sort_d[0] = gt[0] ? key : sort_q[0];
    for (int p = 1; p <= WINDOW_SPAN; p++) begin
      if (gt[p-1]) begin
        sort_d[p] = sort_q[p-1];
      end else if (gt[p]) begin
        sort_d[p] = key;
      end else begin
        sort_d[p] = sort_q[p];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.insert) begin
      for (int p = 0; p <= WINDOW_SPAN; p++) begin
        sort_q[p] <= sort_d[p];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      median_q   <= lead_ok_q ? sort_q[MID] : '0;
      lead_out_q <= lead_q;
    end
  end

  assign sts_o.last_step = last_step;
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign median_o    = median_q;
  assign lead_o      = lead_out_q;

endmodule
